### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Each macro expands to one labeled concurrent assertion that is clocked
// on the rising edge and switched off while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property form: the whole property is passed in.
`define CHK_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("port check failed");

// Overlapping implication form: antecedent and consequent are passed in.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("port implication check failed");

`endif

### rtl/core/vn29_pkg.sv
`default_nettype none

package vn29_pkg;

	localparam int unsigned CODE_W = 5;
	localparam int unsigned INT_W  = 8;

	localparam logic [CODE_W-1:0] CODE_MAX = 5'd28;

	// Flag bits of the internal state form.
	localparam logic [INT_W-1:0] F_CONF = 8'h10;
	localparam logic [INT_W-1:0] F_ORD  = 8'h20;
	localparam logic [INT_W-1:0] F_SPC  = 8'h40;
	localparam logic [INT_W-1:0] F_EXC  = 8'h80;

	// Directions carried in the two low bits.
	localparam logic [1:0] DIR_E = 2'd0;
	localparam logic [1:0] DIR_N = 2'd1;
	localparam logic [1:0] DIR_W = 2'd2;
	localparam logic [1:0] DIR_S = 2'd3;

	localparam logic [1:0] DIR_FLIP = 2'd2;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [INT_W-1:0]  cell_t;

	// Kinds of excitation that reach the center cell.
	typedef struct packed {
		logic conf;
		logic ordq;
		logic spc;
		logic ord;
	} hit_t;

	// Successors of the sensitized chain once it runs past code 8.
	localparam cell_t SENS_NEXT [9] = '{
		8'h22, 8'h23, 8'h40, 8'h41, 8'h42, 8'h43, 8'h10, 8'h20, 8'h21
	};

	// Compact code to internal form; codes above the legal range read as ground.
	function automatic cell_t expand(input code_t code);
		cell_t r;
		begin
			case (code) inside
				[5'd0:5'd8]:   r = {3'b000, code};
				5'd9:          r = 8'h10;
				5'd10:         r = 8'h11;
				[5'd11:5'd14]: r = F_ORD | {6'd0, 2'(code - 5'd11)};
				[5'd15:5'd18]: r = F_SPC | {6'd0, 2'(code - 5'd15)};
				5'd19:         r = 8'h90;
				5'd20:         r = 8'h91;
				[5'd21:5'd24]: r = F_EXC | F_ORD | {6'd0, 2'(code - 5'd21)};
				[5'd25:5'd28]: r = F_EXC | F_SPC | {6'd0, 2'(code - 5'd25)};
				default:       r = '0;
			endcase
			return r;
		end
	endfunction

	// Internal form back to the compact code.
	function automatic code_t compact(input cell_t c);
		code_t r;
		begin
			case (c) inside
				[8'h00:8'h08]: r = code_t'(c[3:0]);
				8'h10:         r = 5'd9;
				8'h11:         r = 5'd10;
				[8'h20:8'h23]: r = 5'd11 + {3'd0, c[1:0]};
				[8'h40:8'h43]: r = 5'd15 + {3'd0, c[1:0]};
				8'h90:         r = 5'd19;
				8'h91:         r = 5'd20;
				[8'hA0:8'hA3]: r = 5'd21 + {3'd0, c[1:0]};
				[8'hC0:8'hC3]: r = 5'd25 + {3'd0, c[1:0]};
				default:       r = '0;
			endcase
			return r;
		end
	endfunction

	// Excitation that neighbor nb sends to center ctr; dir is the direction
	// in which nb has to point to face the center.
	function automatic hit_t hits(input cell_t ctr, input cell_t nb, input logic [1:0] dir);
		hit_t h;
		logic ctr_tx;
		begin
			h = '0;
			ctr_tx = |(ctr & (F_ORD | F_SPC));
			if (|(nb & F_CONF)) begin
				// A confluent cell does not feed a transmission cell aimed at it.
				if (!(ctr_tx && ((ctr[1:0] ^ DIR_FLIP) == dir)))
					h.conf = nb[0];
			end else if (nb[1:0] == dir) begin
				if (|(nb & F_ORD)) begin
					h.ord  = nb[7];
					h.ordq = ~nb[7];
				end else if ((nb & (F_SPC | F_EXC)) == (F_SPC | F_EXC)) begin
					h.spc = 1'b1;
				end
			end
			return h;
		end
	endfunction

	// Next internal state of the center from its state and the hit mask.
	function automatic cell_t next_state(input cell_t c, input hit_t m);
		cell_t r;
		logic [4:0] sum;
		begin
			sum = {c[3:0], 1'b0} + {4'd0, (m.ord | m.spc)};
			if (c < F_CONF) begin
				// Ground and sensitized states walk the construction tree.
				if (sum > 5'd8)
					r = SENS_NEXT[4'(sum - 5'd9)];
				else
					r = {3'b000, sum};
			end else if (|(c & F_CONF)) begin
				if (m.spc)
					r = '0;
				else if (m.ord && !m.ordq)
					r = F_EXC | F_CONF | {7'd0, c[7]};
				else
					r = F_CONF | {7'd0, c[7]};
			end else begin
				if ((|(c & F_ORD) && m.spc) || (|(c & F_SPC) && m.ord))
					r = '0;
				else if (m.spc || m.ord || m.conf)
					r = c | F_EXC;
				else
					r = c & ~F_EXC;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/core/vn29_excite.sv
`default_nettype none

// Gathers the excitation that the four orthogonal neighbors deliver to the center.
module vn29_excite (
	input  wire vn29_pkg::cell_t ctr,
	input  wire vn29_pkg::cell_t north,
	input  wire vn29_pkg::cell_t west,
	input  wire vn29_pkg::cell_t east,
	input  wire vn29_pkg::cell_t south,
	output vn29_pkg::hit_t  mask
);

	vn29_pkg::hit_t h_n, h_w, h_e, h_s;

	// Transmission neighbors must point toward the center to count; confluent ones need not.
	assign h_n = vn29_pkg::hits(ctr, north, vn29_pkg::DIR_S);
	assign h_w = vn29_pkg::hits(ctr, west,  vn29_pkg::DIR_E);
	assign h_e = vn29_pkg::hits(ctr, east,  vn29_pkg::DIR_W);
	assign h_s = vn29_pkg::hits(ctr, south, vn29_pkg::DIR_N);

	assign mask = h_n | h_w | h_e | h_s;

endmodule

`default_nettype wire

### rtl/core/von_neumann_29_state_cell_update.sv
// One-cell update for von Neumann's 29-state cellular automaton.
// The input channel (in_valid/in_ready) carries one neighborhood per item:
// the compact 0..28 codes of the center cell and its north, west, east and
// south neighbors. Codes 29..31 are read as the ground state. The output
// channel (out_valid/out_ready) returns the compact next code of the center.
// The datapath is four register stages: code expansion, neighbor excitation
// mask, next-state rule, and compaction into the output register. An accepted
// item moves through the stage 1, stage 2 and stage 3 registers into the
// output register, where out_valid rises; a stall can hold it between them.
// The block takes one item every cycle for as long as out_ready stays high.
// When the receiver stalls, the stages fill up behind the output register;
// once every stage holds an item, in_ready drops until the output moves.
// in_ready is worked out from out_ready and the valid bits of the stages
// ahead, so no item is dropped or repeated under any stall pattern.
// Reset clears all valid bits, leaving the pipeline empty with in_ready high.
// The block holds no state between items.
`default_nettype none

module von_neumann_29_state_cell_update (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [4:0]            center_code,
	input  wire  [4:0]            north_code,
	input  wire  [4:0]            west_code,
	input  wire  [4:0]            east_code,
	input  wire  [4:0]            south_code,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [4:0]            next_code
);

	// Stage 1: expanded internal forms.
	logic            v_s1;
	vn29_pkg::cell_t ctr_s1, north_s1, west_s1, east_s1, south_s1;

	// Stage 2: center state and the mask of arriving excitations.
	logic            v_s2;
	vn29_pkg::cell_t ctr_s2;
	vn29_pkg::hit_t  mask_s2;

	// Stage 3: next internal state.
	logic            v_s3;
	vn29_pkg::cell_t nxt_s3;

	// Output register.
	logic            out_valid_q;
	vn29_pkg::code_t next_code_q;

	vn29_pkg::hit_t  mask_c;

	// A stage may load when it is empty or when its content moves on.
	logic en_out, en3, en2, en1;

	assign en_out   = !out_valid_q || out_ready;
	assign en3      = !v_s3 || en_out;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	vn29_excite u_excite (
		.ctr   (ctr_s1),
		.north (north_s1),
		.west  (west_s1),
		.east  (east_s1),
		.south (south_s1),
		.mask  (mask_c)
	);

	// Valid bits are control state and are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
			if (en_out)
				out_valid_q <= v_s3;
		end
	end

	// Payload registers load only with a valid item and need no reset.
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ctr_s1   <= vn29_pkg::expand(center_code);
			north_s1 <= vn29_pkg::expand(north_code);
			west_s1  <= vn29_pkg::expand(west_code);
			east_s1  <= vn29_pkg::expand(east_code);
			south_s1 <= vn29_pkg::expand(south_code);
		end
		if (en2 && v_s1) begin
			ctr_s2  <= ctr_s1;
			mask_s2 <= mask_c;
		end
		if (en3 && v_s2)
			nxt_s3 <= vn29_pkg::next_state(ctr_s2, mask_s2);
		if (en_out && v_s3)
			next_code_q <= vn29_pkg::compact(nxt_s3);
	end

	assign out_valid = out_valid_q;
	assign next_code = next_code_q;

endmodule

`default_nettype wire

### rtl/core/vn29_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks of the cell update pipeline.
module vn29_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire [4:0] center_code,
	input wire [4:0] north_code,
	input wire [4:0] west_code,
	input wire [4:0] east_code,
	input wire [4:0] south_code,
	input wire       out_valid,
	input wire       out_ready,
	input wire [4:0] next_code
);

	logic        in_fire;
	logic [24:0] in_data;

	assign in_fire = in_valid && in_ready;
	assign in_data = {center_code, north_code, west_code, east_code, south_code};

	// An item that waits at the input is held with its value.
	`CHK_ASSERT(a_in_hold, clk, arst_n, in_valid && !in_ready |=> in_valid && $stable(in_data))

	// A stalled result is held with its value.
	`CHK_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(next_code))

	// Every result is a legal compact code.
	`CHK_IMPLY(a_code_range, clk, arst_n, out_valid, next_code <= vn29_pkg::CODE_MAX)

	// With the receiver ready, the pipeline never pushes back.
	`CHK_IMPLY(a_no_backpressure, clk, arst_n, out_ready, in_ready)

	// An accepted item shows up at the output when out_ready stays high behind it.
	`CHK_ASSERT(a_latency, clk, arst_n, in_fire ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)

endmodule

bind von_neumann_29_state_cell_update vn29_checker u_vn29_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.center_code (center_code),
	.north_code  (north_code),
	.west_code   (west_code),
	.east_code   (east_code),
	.south_code  (south_code),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.next_code   (next_code)
);

`default_nettype wire
